// ----- rtl/core/kct_pkg.sv -----
// ----------------------------------------------------------------------------
// kct_pkg
// Types and constants shared by the keyed code table cells and top level.
// ----------------------------------------------------------------------------
package kct_pkg;

   localparam int KEY_W  = 64;
   localparam int CODE_W = 16;
   localparam int TIME_W = 64;
   localparam int MODE_W = 2;

   // request mode codes as they arrive in req_tuser
   localparam logic [MODE_W-1:0] MODE_SET    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAN  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

   // operation broadcast down the row of cells
   typedef enum logic [1:0] {
      OP_NOP,
      OP_SET,
      OP_CLEAN,
      OP_LOOKUP
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // command seen by every cell in the same cycle
   typedef struct packed {
      logic              commit;
      op_type            op;
      logic [KEY_W-1:0]  key;
      logic [CODE_W-1:0] code;
   } cmd_type;

   // priority flags handed from one cell to the next (lowest slot first)
   typedef struct packed {
      logic set_taken;
      logic hit_taken;
   } chain_type;

endpackage

// ----- rtl/core/kct_cell.sv -----
// ----------------------------------------------------------------------------
// kct_cell
// One table slot: key and code registers, match logic and priority link.
// ----------------------------------------------------------------------------
module kct_cell #(
   parameter bit STICKY = 1'b1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  kct_pkg::cmd_type           cmd,
   input  kct_pkg::chain_type         chain_in,
   output kct_pkg::chain_type         chain_out,
   output logic [kct_pkg::CODE_W-1:0] code_pick
);

   logic [kct_pkg::KEY_W-1:0]  key_ff,  key_in;
   logic [kct_pkg::CODE_W-1:0] code_ff, code_in;

   logic match, empty, hit, set_want, set_mine, hit_mine, purge;

   always_comb begin
      match    = (key_ff == cmd.key);
      empty    = (key_ff == '0);
      hit      = match && (code_ff != '0);
      set_want = match || empty;
      set_mine = set_want && !chain_in.set_taken;
      hit_mine = hit && !chain_in.hit_taken;
      // lookup drops occupied non-sticky slots unless they hit on the lookup key
      purge    = !STICKY && !hit && !empty;

      chain_out.set_taken = chain_in.set_taken || set_want;
      chain_out.hit_taken = chain_in.hit_taken || hit;
      code_pick = hit_mine ? code_ff : '0;

      key_in  = key_ff;
      code_in = code_ff;
      if (cmd.commit) begin
         unique case (cmd.op)
            kct_pkg::OP_SET: begin
               if (set_mine) begin
                  key_in  = cmd.key;
                  code_in = cmd.code;
               end
            end
            kct_pkg::OP_CLEAN: begin
               if (match) begin
                  key_in  = '0;
                  code_in = '0;
               end
            end
            kct_pkg::OP_LOOKUP: begin
               if (purge) begin
                  key_in  = '0;
                  code_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         code_ff <= '0;
      end else begin
         key_ff  <= key_in;
         code_ff <= code_in;
      end
   end

endmodule

// ----- rtl/core/keyed_code_table_top.sv -----
// ----------------------------------------------------------------------------
// keyed_code_table_top
// Associative key/code table built as a row of slot cells.
// ----------------------------------------------------------------------------
// rsp_tvalid is registered: it rises at the edge that ends the execute cycle that commits.
// The single command register accepts a new item only in idle: it holds one item
// through the latch cycle and the compare/priority/commit cycle of the cells.
// A stalled response holds the command in execute until the output frees.
// Reset (synchronous, active high) empties every slot and drops any response.
// ----------------------------------------------------------------------------
module keyed_code_table_top #(
   parameter int SLOTS        = 31,
   parameter int STICKY_SLOTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,  // key[63:0], code_in[79:64], time_s[143:80]
   input  logic [1:0]   req_tuser,  // mode[1:0]
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,  // status[0], code_out[16:1],
                                    // notify_key[80:17], notify_time[144:81],
                                    // zero fill[151:145]
   output logic         rsp_tuser   // notify
);

   localparam int RSP_USED = 1 + kct_pkg::CODE_W + kct_pkg::KEY_W + kct_pkg::TIME_W;
   localparam int RSP_PAD  = 152 - RSP_USED;

   // ---------------- control
   kct_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, commit;

   // ---------------- latched command
   logic [kct_pkg::MODE_W-1:0] mode_ff;
   logic [kct_pkg::KEY_W-1:0]  key_ff;
   logic [kct_pkg::CODE_W-1:0] code_ff;
   logic [kct_pkg::TIME_W-1:0] time_ff;

   // ---------------- response payload
   logic [151:0] rsp_data_ff, rsp_data_in;
   logic         rsp_user_ff, rsp_user_in;

   // ---------------- cell row
   kct_pkg::cmd_type   cmd;
   kct_pkg::chain_type chain [SLOTS+1];
   logic [kct_pkg::CODE_W-1:0] code_pick [SLOTS];
   logic [kct_pkg::CODE_W-1:0] code_found;
   logic set_ok;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == kct_pkg::ST_EXEC) && out_free;
   assign req_tready = (state_ff == kct_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // a set needs a nonzero key and a nonzero code
   assign set_ok = (key_ff != '0) && (code_ff != '0);

   always_comb begin
      cmd.commit = commit;
      cmd.key    = key_ff;
      cmd.code   = code_ff;
      unique case (mode_ff)
         kct_pkg::MODE_SET:    cmd.op = set_ok ? kct_pkg::OP_SET : kct_pkg::OP_NOP;
         kct_pkg::MODE_CLEAN:  cmd.op = kct_pkg::OP_CLEAN;
         kct_pkg::MODE_LOOKUP: cmd.op = kct_pkg::OP_LOOKUP;
         default:              cmd.op = kct_pkg::OP_NOP;
      endcase
   end

   // slot 0 has top priority: nothing is taken before it
   assign chain[0].set_taken = 1'b0;
   assign chain[0].hit_taken = 1'b0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      kct_cell #(
         .STICKY (i < STICKY_SLOTS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .code_pick (code_pick[i])
      );
   end

   // at most one cell drives a nonzero pick, so an OR tree merges them
   always_comb begin
      code_found = '0;
      for (int i = 0; i < SLOTS; i++) begin
         code_found = code_found | code_pick[i];
      end
   end

   // response build: fields ordered status, code_out, notify_key, notify_time
   always_comb begin
      logic                       status;
      logic [kct_pkg::CODE_W-1:0] code_out;
      logic                       notify;
      status   = 1'b0;
      code_out = '0;
      notify   = 1'b0;
      unique case (mode_ff)
         kct_pkg::MODE_SET: begin
            status = !set_ok;
            notify = set_ok && chain[SLOTS].set_taken;
         end
         kct_pkg::MODE_LOOKUP: begin
            status   = chain[SLOTS].hit_taken;
            code_out = code_found;
         end
         default: begin
         end
      endcase
      rsp_user_in = notify;
      rsp_data_in = {{RSP_PAD{1'b0}},
                     notify ? time_ff : {kct_pkg::TIME_W{1'b0}},
                     notify ? key_ff  : {kct_pkg::KEY_W{1'b0}},
                     code_out,
                     status};
   end

   // sequencer: idle takes an item, execute commits once the output is free
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         kct_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = kct_pkg::ST_EXEC;
         end
         kct_pkg::ST_EXEC: begin
            if (out_free) begin
               state_in     = kct_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = kct_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kct_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         mode_ff <= req_tuser;
         key_ff  <= req_tdata[63:0];
         code_ff <= req_tdata[79:64];
         time_ff <= req_tdata[143:80];
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   // ---------------- assertions
   // a commit always returns the sequencer to idle with a response pending
   a_commit_idle : assert property (@(posedge clock) disable iff (reset)
      commit |=> (state_ff == kct_pkg::ST_IDLE) && rsp_valid_ff)
      else $error("commit did not return to idle with a response");

   // a notify only comes from a successful set of a nonzero key
   a_notify_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |-> (!rsp_data_ff[0] && (rsp_data_ff[80:17] != '0)))
      else $error("notify with failure status or empty key");

   // a lookup that finds nothing returns a zero code
   a_lookup_zero : assert property (@(posedge clock) disable iff (reset)
      (commit && (mode_ff == kct_pkg::MODE_LOOKUP) && !chain[SLOTS].hit_taken)
         |-> (code_found == '0))
      else $error("lookup miss with nonzero code");

endmodule
